### rtl/fsrv_pkg.sv
// fsrv_pkg: shared types and constants for the fiat-shamir round verifier
// no dependencies; used by the interfaces, the modular multiplier and the top level

package fsrv_pkg;

  localparam int DATA_W    = 31;
  localparam int ROUNDS_W  = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECRET  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUNDS  = 2'd2;

  localparam logic [DATA_W-1:0]   MODULUS_RST = 31'd2;
  localparam logic [DATA_W-1:0]   SECRET_RST  = 31'd1;
  localparam logic [ROUNDS_W-1:0] ROUNDS_RST  = 8'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUBLIC,
    S_COMMIT,
    S_RESP,
    S_LHS,
    S_RHS,
    S_FIN
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mm_stat_t;

endpackage

### rtl/fsrv_ifs.sv
// fsrv_ifs: valid/ready channel interfaces for input items, results and config writes
// depends on fsrv_pkg

interface fsrv_item_if
  import fsrv_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] witness;
  logic              challenge;
  modport source (output valid, output witness, output challenge, input ready);
  modport sink   (input valid, input witness, input challenge, output ready);
endinterface

interface fsrv_result_if
  import fsrv_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] commitment;
  logic [DATA_W-1:0] response;
  logic              round_ok;
  logic              witness_in_range;
  logic              session_done;
  logic              session_ok;
  modport source (output valid, output commitment, output response, output round_ok,
                  output witness_in_range, output session_done, output session_ok,
                  input ready);
  modport sink   (input valid, input commitment, input response, input round_ok,
                  input witness_in_range, input session_done, input session_ok,
                  output ready);
endinterface

interface fsrv_cfg_if
  import fsrv_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/fsrv_modmul.sv
// fsrv_modmul: (a*b) mod n, one multiply then a shift-subtract reduction, one bit a cycle
// depends on fsrv_pkg for the status struct

module fsrv_modmul
  import fsrv_pkg::*;
#(
  parameter int W = 31
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] op_a,
  input  logic [W-1:0] op_b,
  input  logic [W-1:0] n,
  output mm_stat_t     stat,
  output logic [W-1:0] result
);

  localparam int PW = 2 * W;
  localparam int CW = $clog2(PW + 1);

  logic [PW-1:0] prod;
  logic [W-1:0]  rem;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;

  logic [W:0] trial;
  logic [W:0] diff;
  logic       ge;

  assign trial = {rem, prod[PW-1]};
  assign diff  = trial - {1'b0, n};
  assign ge    = trial >= {1'b0, n};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= CW'(PW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      prod <= op_a * op_b;
      rem  <= '0;
    end else if (busy) begin
      prod <= {prod[PW-2:0], 1'b0};
      rem  <= ge ? diff[W-1:0] : trial[W-1:0];
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign result    = (n == '0) ? '0 : rem;

endmodule

### rtl/fiat_shamir_round_verifier_top.sv
// fiat_shamir_round_verifier_top: sequencer around one shared modular multiplier
// depends on fsrv_pkg, fsrv_ifs and fsrv_modmul
//
// One witness beat is taken at a time; the block drops item.ready until the round is
// finished and loaded into the result register, which lets the next witness in while a
// result still waits. All arithmetic runs through one modular multiplier (one multiply,
// one remainder bit a cycle). A round uses four products (x*x, x*s or x*1, y*y, a*v),
// three when the challenge is 0, plus s*s on the first round of a session: 3 to 5 products.
// A round waits in its final state while the result register holds a stalled result.
// Config writes are taken every cycle and must only be issued while the block is idle.

module fiat_shamir_round_verifier_top
  import fsrv_pkg::*;
#(
  parameter int MOD_WIDTH  = 31,
  parameter int MAX_ROUNDS = 255
) (
  input  logic          clk,
  input  logic          rst,
  fsrv_item_if.sink     item,
  fsrv_result_if.source result,
  fsrv_cfg_if.sink      cfg
);

  localparam int W = MOD_WIDTH;

  state_t state, state_next;

  logic [DATA_W-1:0]   modulus;
  logic [DATA_W-1:0]   secret;
  logic [ROUNDS_W-1:0] rounds;

  logic [ROUNDS_W-1:0] round_index;
  logic                session_failed;
  logic [W-1:0]        public_value;

  logic [W-1:0] x;
  logic         e;
  logic         x_in_range;
  logic [W-1:0] a;
  logic [W-1:0] y;
  logic [W-1:0] lhs;
  logic [W-1:0] rhs;

  logic              res_valid;
  logic [DATA_W-1:0] res_commitment;
  logic [DATA_W-1:0] res_response;
  logic              res_round_ok;
  logic              res_in_range;
  logic              res_done;
  logic              res_session_ok;

  logic [W-1:0]  n;
  logic [W-1:0]  s;
  logic          mm_start;
  logic [W-1:0]  mm_a;
  logic [W-1:0]  mm_b;
  mm_stat_t      mm_stat;
  logic [W-1:0]  mm_result;

  logic                item_beat;
  logic                out_free;
  logic [ROUNDS_W-1:0] limit;
  logic                last_round;
  logic                pass;
  logic                failed_now;

  assign n = modulus[W-1:0];
  assign s = secret[W-1:0];

  assign item_beat = item.valid && item.ready;
  assign out_free  = !res_valid || result.ready;

  assign limit      = (32'(rounds) > MAX_ROUNDS) ? ROUNDS_W'(MAX_ROUNDS) : rounds;
  assign last_round = ({1'b0, round_index} + (ROUNDS_W+1)'(1)) >= {1'b0, limit};
  assign pass       = (lhs == rhs);
  assign failed_now = session_failed || !pass;

  fsrv_modmul #(.W(W)) u_modmul (
    .clk    (clk),
    .rst    (rst),
    .start  (mm_start),
    .op_a   (mm_a),
    .op_b   (mm_b),
    .n      (n),
    .stat   (mm_stat),
    .result (mm_result)
  );

  // config port
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MODULUS_RST;
      secret  <= SECRET_RST;
      rounds  <= ROUNDS_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_MODULUS: modulus <= cfg.data;
        CFG_SECRET:  secret  <= cfg.data;
        CFG_ROUNDS: begin
          if (cfg.data[ROUNDS_W-1:0] != '0) rounds <= cfg.data[ROUNDS_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item_beat) state_next = (round_index == '0) ? S_PUBLIC : S_COMMIT;
      end
      S_PUBLIC: if (mm_stat.done) state_next = S_COMMIT;
      S_COMMIT: if (mm_stat.done) state_next = S_RESP;
      S_RESP:   if (mm_stat.done) state_next = S_LHS;
      S_LHS:    if (mm_stat.done) state_next = e ? S_RHS : S_FIN;
      S_RHS:    if (mm_stat.done) state_next = S_FIN;
      S_FIN:    if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    item.ready = 1'b0;
    mm_start   = 1'b0;
    mm_a       = x;
    mm_b       = x;
    unique case (state)
      S_IDLE: item.ready = 1'b1;
      S_PUBLIC: begin
        mm_a = s;
        mm_b = s;
      end
      S_COMMIT: begin
        mm_a = x;
        mm_b = x;
      end
      S_RESP: begin
        mm_a = x;
        mm_b = e ? s : W'(1);
      end
      S_LHS: begin
        mm_a = y;
        mm_b = y;
      end
      S_RHS: begin
        mm_a = a;
        mm_b = public_value;
      end
      S_FIN: ;
      default: ;
    endcase
    if (state != S_IDLE && state != S_FIN && !mm_stat.busy && !mm_stat.done) mm_start = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && item_beat) begin
      x          <= item.witness[W-1:0];
      e          <= item.challenge;
      x_in_range <= item.witness[W-1:0] < n;
    end
    if (mm_stat.done) begin
      unique case (state)
        S_PUBLIC: public_value <= mm_result;
        S_COMMIT: a            <= mm_result;
        S_RESP:   y            <= mm_result;
        S_LHS: begin
          lhs <= mm_result;
          if (!e) rhs <= a;
        end
        S_RHS:    rhs          <= mm_result;
        default: ;
      endcase
    end
  end

  // session state
  always_ff @(posedge clk) begin
    if (rst) begin
      round_index    <= '0;
      session_failed <= 1'b0;
    end else if (state == S_FIN && out_free) begin
      if (last_round) begin
        round_index    <= '0;
        session_failed <= 1'b0;
      end else begin
        round_index    <= round_index + ROUNDS_W'(1);
        session_failed <= failed_now;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      if (result.ready) res_valid <= 1'b0;
      if (state == S_FIN && out_free) res_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      res_commitment <= DATA_W'(a);
      res_response   <= DATA_W'(y);
      res_round_ok   <= pass && !session_failed;
      res_in_range   <= x_in_range;
      res_done       <= last_round;
      res_session_ok <= !failed_now;
    end
  end

  assign result.valid            = res_valid;
  assign result.commitment       = res_commitment;
  assign result.response         = res_response;
  assign result.round_ok         = res_round_ok;
  assign result.witness_in_range = res_in_range;
  assign result.session_done     = res_done;
  assign result.session_ok       = res_session_ok;

endmodule

### rtl/fsrv_checker.sv
// fsrv_checker: port-level assertions for the fiat-shamir round verifier, and its bind
// depends on fsrv_pkg and fiat_shamir_round_verifier_top

module fsrv_checker
  import fsrv_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_ready,
  input logic              res_valid,
  input logic              res_ready,
  input logic [DATA_W-1:0] res_commitment,
  input logic [DATA_W-1:0] res_response,
  input logic              res_round_ok,
  input logic              res_session_ok
);

  // one round in flight: an accepted beat closes the input
  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("input still open after a witness beat");

  // a new result only comes out of a round in progress
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(!item_ready))
    else $error("result appeared without a round in progress");

  // a passing round cannot sit in a failed session
  a_ok_implies_session: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_round_ok |-> res_session_ok)
    else $error("round_ok set while session_ok clear");

  // stalled result beat holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=>
      res_valid && $stable(res_commitment) && $stable(res_response))
    else $error("result beat changed while stalled");

endmodule

bind fiat_shamir_round_verifier_top fsrv_checker u_fsrv_checker (
  .clk            (clk),
  .rst            (rst),
  .item_valid     (item.valid),
  .item_ready     (item.ready),
  .res_valid      (result.valid),
  .res_ready      (result.ready),
  .res_commitment (result.commitment),
  .res_response   (result.response),
  .res_round_ok   (result.round_ok),
  .res_session_ok (result.session_ok)
);
